// ----- src/dqpc_pkg.sv -----
// shared constants and types for the dual quadrature people counter
// used by dqpc_door and dual_quadrature_people_counter; no dependencies
package dqpc_pkg;

	// default widths and reset value
	localparam int COUNT_WIDTH_DFLT  = 16;
	localparam int SAMPLE_WIDTH_DFLT = 10;
	localparam int THRESHOLD_RESET   = 400;

	typedef logic [1:0] phase_t;

	// quadrature phase codes
	localparam phase_t PH_BOTH_DARK   = 2'd0;
	localparam phase_t PH_SECOND_DARK = 2'd1;
	localparam phase_t PH_NONE_DARK   = 2'd2;
	localparam phase_t PH_FIRST_DARK  = 2'd3;

	// phase difference codes, new minus old mod 4
	localparam phase_t DIFF_FWD  = 2'd1;
	localparam phase_t DIFF_BACK = 2'd3;

endpackage

// ----- src/dual_quadrature_people_counter.sv -----
// Dual quadrature people counter. Each request on the input stream carries four light samples,
// two per door; a sample below dark_threshold is dark, and each door's pair of dark bits
// forms a quadrature phase whose forward and backward steps move that door's saturating edge
// count. Each result holds both counts and the sum of each count divided by four toward zero.
// One request is taken every clock cycle while the sink takes results; a result passes through
// the input register and then the result register before it appears on the output,
// and the counts are updated in the same single cycle that loads the result register. A
// result held back by the sink stalls the input once the input register is also full.
// Write dark_threshold only while idle.
// Depends on dqpc_pkg and dqpc_door.
module dual_quadrature_people_counter #(
	parameter int COUNT_WIDTH  = dqpc_pkg::COUNT_WIDTH_DFLT,
	parameter int SAMPLE_WIDTH = dqpc_pkg::SAMPLE_WIDTH_DFLT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// sample_a1, sample_a2, sample_b1, sample_b2, zero fill
	input  logic [((4*SAMPLE_WIDTH+7)/8)*8-1:0]  s_axis_tdata,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// total_persons, edge_count_a, edge_count_b, zero fill
	output logic [((3*COUNT_WIDTH-1+7)/8)*8-1:0] m_axis_tdata,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [SAMPLE_WIDTH-1:0]       cfg_data
);

	localparam int OUT_TDATA_W = ((3*COUNT_WIDTH-1+7)/8)*8;
	localparam int TOTAL_W     = COUNT_WIDTH - 1;
	localparam int QUOT_W      = COUNT_WIDTH - 2;

	logic [SAMPLE_WIDTH-1:0] thr_q;

	logic                    valid_s1;
	logic [SAMPLE_WIDTH-1:0] sa1_s1;
	logic [SAMPLE_WIDTH-1:0] sa2_s1;
	logic [SAMPLE_WIDTH-1:0] sb1_s1;
	logic [SAMPLE_WIDTH-1:0] sb2_s1;

	dqpc_pkg::phase_t              phase_a_q;
	dqpc_pkg::phase_t              phase_b_q;
	logic                          known_q;
	logic signed [COUNT_WIDTH-1:0] count_a_q;
	logic signed [COUNT_WIDTH-1:0] count_b_q;

	logic                          valid_s2;
	logic signed [TOTAL_W-1:0]     total_s2;
	logic signed [COUNT_WIDTH-1:0] count_a_s2;
	logic signed [COUNT_WIDTH-1:0] count_b_s2;

	dqpc_pkg::phase_t              phase_a_nx;
	dqpc_pkg::phase_t              phase_b_nx;
	logic signed [COUNT_WIDTH-1:0] step_a;
	logic signed [COUNT_WIDTH-1:0] step_b;
	logic signed [COUNT_WIDTH-1:0] clr_a;
	logic signed [COUNT_WIDTH-1:0] clr_b;
	logic signed [COUNT_WIDTH-1:0] adj_a;
	logic signed [COUNT_WIDTH-1:0] adj_b;
	logic signed [QUOT_W-1:0]      quot_a;
	logic signed [QUOT_W-1:0]      quot_b;
	logic signed [TOTAL_W-1:0]     total;

	logic in_fire;
	logic adv;

	assign adv           = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;

	dqpc_door #(.COUNT_WIDTH(COUNT_WIDTH), .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_door_a (
		.sample1     (sa1_s1),
		.sample2     (sa2_s1),
		.threshold   (thr_q),
		.phase_old   (phase_a_q),
		.phase_known (known_q),
		.count_old   (count_a_q),
		.phase_new   (phase_a_nx),
		.count_new   (step_a)
	);

	dqpc_door #(.COUNT_WIDTH(COUNT_WIDTH), .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_door_b (
		.sample1     (sb1_s1),
		.sample2     (sb2_s1),
		.threshold   (thr_q),
		.phase_old   (phase_b_q),
		.phase_known (known_q),
		.count_old   (count_b_q),
		.phase_new   (phase_b_nx),
		.count_new   (step_b)
	);

	// negative count clearing, door a first, then door b against the updated a
	always_comb begin
		clr_a = step_a;
		if (step_a < 0 && step_b <= 0) begin
			clr_a = '0;
		end
		clr_b = step_b;
		if (step_b < 0 && clr_a <= 0) begin
			clr_b = '0;
		end
	end

	// divide by four toward zero: bias negatives by three, then drop two bits
	assign adj_a  = clr_a + COUNT_WIDTH'({clr_a[COUNT_WIDTH-1], clr_a[COUNT_WIDTH-1]});
	assign adj_b  = clr_b + COUNT_WIDTH'({clr_b[COUNT_WIDTH-1], clr_b[COUNT_WIDTH-1]});
	assign quot_a = adj_a[COUNT_WIDTH-1:2];
	assign quot_b = adj_b[COUNT_WIDTH-1:2];
	assign total  = TOTAL_W'(quot_a) + TOTAL_W'(quot_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= SAMPLE_WIDTH'(dqpc_pkg::THRESHOLD_RESET);
		end else if (cfg_valid) begin
			thr_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			sa1_s1 <= s_axis_tdata[SAMPLE_WIDTH-1:0];
			sa2_s1 <= s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
			sb1_s1 <= s_axis_tdata[3*SAMPLE_WIDTH-1:2*SAMPLE_WIDTH];
			sb2_s1 <= s_axis_tdata[4*SAMPLE_WIDTH-1:3*SAMPLE_WIDTH];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_a_q <= dqpc_pkg::PH_BOTH_DARK;
			phase_b_q <= dqpc_pkg::PH_BOTH_DARK;
			known_q   <= 1'b0;
			count_a_q <= '0;
			count_b_q <= '0;
			valid_s2  <= 1'b0;
		end else begin
			if (adv) begin
				phase_a_q <= phase_a_nx;
				phase_b_q <= phase_b_nx;
				known_q   <= 1'b1;
				count_a_q <= clr_a;
				count_b_q <= clr_b;
				valid_s2  <= 1'b1;
			end else if (m_axis_tready) begin
				valid_s2  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			total_s2   <= total;
			count_a_s2 <= clr_a;
			count_b_s2 <= clr_b;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = OUT_TDATA_W'({count_b_s2, count_a_s2, total_s2});

endmodule

// ----- src/dqpc_door.sv -----
// one door: decode two light samples into a quadrature phase and step the edge count
// uses dqpc_pkg
module dqpc_door #(
	parameter int COUNT_WIDTH  = dqpc_pkg::COUNT_WIDTH_DFLT,
	parameter int SAMPLE_WIDTH = dqpc_pkg::SAMPLE_WIDTH_DFLT
) (
	input  logic [SAMPLE_WIDTH-1:0]       sample1,
	input  logic [SAMPLE_WIDTH-1:0]       sample2,
	input  logic [SAMPLE_WIDTH-1:0]       threshold,
	input  dqpc_pkg::phase_t              phase_old,
	input  logic                          phase_known,
	input  logic signed [COUNT_WIDTH-1:0] count_old,
	output dqpc_pkg::phase_t              phase_new,
	output logic signed [COUNT_WIDTH-1:0] count_new
);

	localparam logic signed [COUNT_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
	localparam logic signed [COUNT_WIDTH-1:0] CNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

	logic             dark1;
	logic             dark2;
	dqpc_pkg::phase_t diff;

	assign dark1 = sample1 < threshold;
	assign dark2 = sample2 < threshold;

	always_comb begin
		case ({dark1, dark2})
			2'b11:   phase_new = dqpc_pkg::PH_BOTH_DARK;
			2'b01:   phase_new = dqpc_pkg::PH_SECOND_DARK;
			2'b00:   phase_new = dqpc_pkg::PH_NONE_DARK;
			2'b10:   phase_new = dqpc_pkg::PH_FIRST_DARK;
			default: phase_new = dqpc_pkg::PH_NONE_DARK;
		endcase
	end

	assign diff = phase_new - phase_old;

	// saturating up/down step, nothing happens before the first phase is seen
	always_comb begin
		count_new = count_old;
		if (phase_known) begin
			if (diff == dqpc_pkg::DIFF_FWD && count_old != CNT_MAX) begin
				count_new = count_old + COUNT_WIDTH'(1);
			end else if (diff == dqpc_pkg::DIFF_BACK && count_old != CNT_MIN) begin
				count_new = count_old - COUNT_WIDTH'(1);
			end
		end
	end

endmodule
